// ----- src/smse_pkg.sv -----
// Shared types, constants and fixed-point helpers of the sparse monomial sum evaluator.
// Depends on nothing; used by smse_ctrl, smse_dp and sparse_monomial_sum_eval.
package smse_pkg;

    localparam int N_FEATURES = 32;
    localparam int MAX_TERMS  = 256;
    localparam int MAX_ORDER  = 6;
    localparam int IDX_W      = 5;
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 6;   // feature count 1..N_FEATURES
    localparam int TERMS_W    = 9;   // term count 0..MAX_TERMS
    localparam int ORD_W      = 3;
    localparam int Q_W        = 18;  // Q3.14
    localparam int ACC_W      = 32;  // Q17.14
    localparam int PROD_W     = ACC_W + Q_W;
    localparam int FRAC       = 14;
    localparam int PACK_W     = IDX_W * MAX_ORDER;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_TERMS = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    typedef struct packed {
        logic                term_rd;
        logic [SLOT_W-1:0]   term_addr;
        logic                p_ld_mult;
        logic                p_ld_grad;
        logic                p_ld_base;
        logic                mul_go;
        logic                mul_b_mult;
        logic                rnd_go;
        logic                base_ld;
        logic                acc_add;
        logic                gacc_rd;
        logic                gacc_rd_out;
        logic                gacc_add;
        logic                out_ld_energy;
        logic                out_ld_grad;
        logic                out_last;
        logic [ORD_W-1:0]    fac_i;
        logic [ORD_W-1:0]    fac_j;
        logic [IDX_W-1:0]    out_pos;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             tgt_ge;
    } sts_t;

    function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                       logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    // round half up, floor shift, saturate
    function automatic logic signed [ACC_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]      r;
        logic signed [PROD_W-FRAC:0] sh;
        r  = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (FRAC-1));
        sh = r[PROD_W:FRAC];
        if (sh > $signed({{(PROD_W-FRAC-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}}))
            round_sat = {1'b0, {(ACC_W-1){1'b1}}};
        else if (sh < $signed({{(PROD_W-FRAC-ACC_W+2){1'b1}}, {(ACC_W-1){1'b0}}}))
            round_sat = {1'b1, {(ACC_W-1){1'b0}}};
        else
            round_sat = sh[ACC_W-1:0];
    endfunction

endpackage

// ----- src/smse_dp.sv -----
// Datapath: term table, feature store, shared multiplier, energy and gradient sums,
// output register. Depends on smse_pkg; driven by smse_ctrl through cmd_t.
module smse_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_acc,
    input  logic                              req_type,
    input  logic [smse_pkg::SLOT_W-1:0]       term_slot,
    input  logic signed [smse_pkg::Q_W-1:0]   term_multiplier,
    input  logic [smse_pkg::PACK_W-1:0]       factor_pack,
    input  logic signed [smse_pkg::Q_W-1:0]   feature_value,
    input  logic signed [smse_pkg::Q_W-1:0]   upstream_gradient,
    input  logic                              last_feature,
    input  smse_pkg::cmd_t                    cmd,
    output smse_pkg::sts_t                    sts,
    output logic signed [smse_pkg::ACC_W-1:0] atom_energy,
    output logic signed [smse_pkg::ACC_W-1:0] feature_gradient,
    output logic [smse_pkg::IDX_W-1:0]        gradient_position,
    output logic                              last_result
);

    logic signed [smse_pkg::Q_W-1:0]    tm_mult_mem [smse_pkg::MAX_TERMS];
    logic [smse_pkg::PACK_W-1:0]        tm_idx_mem  [smse_pkg::MAX_TERMS];
    logic signed [smse_pkg::Q_W-1:0]    tm_mult_q;
    logic [smse_pkg::PACK_W-1:0]        tm_idx_q;

    logic signed [smse_pkg::Q_W-1:0]    fs_reg [smse_pkg::N_FEATURES];
    logic [smse_pkg::IDX_W-1:0]         fpos_reg;
    logic [smse_pkg::CNT_W-1:0]         count_reg;
    logic signed [smse_pkg::Q_W-1:0]    grad_reg;

    logic signed [smse_pkg::ACC_W-1:0]  p_reg, base_reg, acc_reg;
    logic signed [smse_pkg::PROD_W-1:0] prod_reg;

    logic signed [smse_pkg::ACC_W-1:0]  gacc_mem [smse_pkg::N_FEATURES];
    logic [smse_pkg::N_FEATURES-1:0]    gv_reg;
    logic signed [smse_pkg::ACC_W-1:0]  gacc_q;
    logic                               gacc_qv;

    logic signed [smse_pkg::ACC_W-1:0]  energy_reg, grad_out_reg;
    logic [smse_pkg::IDX_W-1:0]         pos_reg;
    logic                               last_reg;

    logic [smse_pkg::IDX_W-1:0]         idx_i, idx_j, gacc_addr;
    logic signed [smse_pkg::Q_W-1:0]    fval, mul_b;
    logic signed [smse_pkg::ACC_W-1:0]  rnd, gold;
    logic                               feat_acc, atom_start;

    assign feat_acc   = in_acc && (req_type == smse_pkg::REQ_FEATURE);
    assign atom_start = feat_acc && last_feature;

    assign idx_i = tm_idx_q[smse_pkg::IDX_W*cmd.fac_i +: smse_pkg::IDX_W];
    assign idx_j = tm_idx_q[smse_pkg::IDX_W*cmd.fac_j +: smse_pkg::IDX_W];
    assign fval  = ({1'b0, idx_j} < count_reg) ? fs_reg[idx_j] : '0;
    assign mul_b = cmd.mul_b_mult ? tm_mult_q : fval;
    assign rnd   = smse_pkg::round_sat(prod_reg);
    assign gold  = gacc_qv ? gacc_q : '0;
    assign gacc_addr = cmd.gacc_rd_out ? cmd.out_pos : idx_i;

    assign sts.count  = count_reg;
    assign sts.tgt_ge = ({1'b0, idx_i} >= count_reg);

    // term table
    always_ff @(posedge clk)
    begin
        if (in_acc && (req_type == smse_pkg::REQ_LOAD))
        begin
            tm_mult_mem[term_slot] <= term_multiplier;
            tm_idx_mem[term_slot]  <= factor_pack;
        end
        if (cmd.term_rd)
        begin
            tm_mult_q <= tm_mult_mem[cmd.term_addr];
            tm_idx_q  <= tm_idx_mem[cmd.term_addr];
        end
    end

    // gradient sums
    always_ff @(posedge clk)
    begin
        if (cmd.gacc_add)
            gacc_mem[idx_i] <= smse_pkg::sat_add(gold, p_reg);
        if (cmd.gacc_rd || cmd.gacc_rd_out)
            gacc_q <= gacc_mem[gacc_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg   <= '0;
            gacc_qv  <= 1'b0;
            fpos_reg <= '0;
        end
        else
        begin
            if (atom_start)
                gv_reg <= '0;
            else if (cmd.gacc_add)
                gv_reg[idx_i] <= 1'b1;
            if (cmd.gacc_rd || cmd.gacc_rd_out)
                gacc_qv <= gv_reg[gacc_addr];
            if (feat_acc)
            begin
                if (last_feature)
                    fpos_reg <= '0;
                else if (fpos_reg != smse_pkg::IDX_W'(smse_pkg::N_FEATURES - 1))
                    fpos_reg <= fpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_acc)
            fs_reg[fpos_reg] <= feature_value;
        if (atom_start)
        begin
            count_reg <= {1'b0, fpos_reg} + 1'b1;
            grad_reg  <= upstream_gradient;
            acc_reg   <= '0;
        end
        else if (cmd.acc_add)
            acc_reg <= smse_pkg::sat_add(acc_reg, p_reg);

        if (cmd.p_ld_mult)
            p_reg <= smse_pkg::ACC_W'(tm_mult_q);
        else if (cmd.p_ld_grad)
            p_reg <= smse_pkg::ACC_W'(grad_reg);
        else if (cmd.p_ld_base)
            p_reg <= base_reg;
        else if (cmd.rnd_go)
            p_reg <= rnd;
        if (cmd.base_ld)
            base_reg <= rnd;
        if (cmd.mul_go)
            prod_reg <= p_reg * mul_b;

        if (cmd.out_ld_energy)
        begin
            energy_reg   <= acc_reg;
            grad_out_reg <= '0;
            pos_reg      <= '0;
            last_reg     <= 1'b1;
        end
        else if (cmd.out_ld_grad)
        begin
            energy_reg   <= '0;
            grad_out_reg <= gold;
            pos_reg      <= cmd.out_pos;
            last_reg     <= cmd.out_last;
        end
    end

    assign atom_energy       = energy_reg;
    assign feature_gradient  = grad_out_reg;
    assign gradient_position = pos_reg;
    assign last_result       = last_reg;

endmodule

// ----- src/smse_ctrl.sv -----
// Controller: configuration registers, term and factor sequencing, output handshake.
// Depends on smse_pkg; commands smse_dp through cmd_t.
module smse_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [smse_pkg::TERMS_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic                         last_feature,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  smse_pkg::sts_t               sts,
    output smse_pkg::cmd_t               cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_TERM = 11'b00000000010,
        S_LOAD = 11'b00000000100,
        S_MUL  = 11'b00000001000,
        S_RND  = 11'b00000010000,
        S_ACC  = 11'b00000100000,
        S_GSEL = 11'b00001000000,
        S_GADD = 11'b00010000000,
        S_EFIN = 11'b00100000000,
        S_GRD  = 11'b01000000000,
        S_GOUT = 11'b10000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [smse_pkg::ORD_W-1:0]   order_reg;
    logic [smse_pkg::TERMS_W-1:0] terms_reg;
    logic                         mode_reg;
    logic [smse_pkg::TERMS_W-1:0] t_reg, t_next;
    logic [smse_pkg::ORD_W-1:0]   i_reg, i_next, j_reg, j_next;
    logic [smse_pkg::IDX_W-1:0]   r_reg, r_next;
    logic                         bph_reg, bph_next;
    logic                         ov_reg, ov_next;
    logic [smse_pkg::ORD_W-1:0]   order_c;
    logic [smse_pkg::TERMS_W-1:0] terms_c;
    logic [smse_pkg::ORD_W:0]     nj;
    logic                         out_free;

    assign order_c = (order_reg < 3'd2) ? 3'd2 :
                     (order_reg > smse_pkg::ORD_W'(smse_pkg::MAX_ORDER)) ?
                     smse_pkg::ORD_W'(smse_pkg::MAX_ORDER) : order_reg;
    assign terms_c = (terms_reg > smse_pkg::TERMS_W'(smse_pkg::MAX_TERMS)) ?
                     smse_pkg::TERMS_W'(smse_pkg::MAX_TERMS) : terms_reg;
    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 3'd2;
            terms_reg <= '0;
            mode_reg  <= 1'b0;
            state_reg <= S_IDLE;
            t_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
            bph_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    smse_pkg::CFG_ORDER: order_reg <= cfg_data[smse_pkg::ORD_W-1:0];
                    smse_pkg::CFG_TERMS: terms_reg <= cfg_data;
                    smse_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            state_reg <= state_next;
            t_reg     <= t_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            bph_reg   <= bph_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        bph_next   = bph_reg;
        ov_next    = ov_reg && !out_ready;
        nj         = {1'b0, j_reg} + 1'b1;
        if (nj[smse_pkg::ORD_W-1:0] == i_reg)
            nj = {1'b0, j_reg} + 2'd2;
        cmd        = '0;
        cmd.term_addr = t_reg[smse_pkg::SLOT_W-1:0];
        cmd.fac_i     = i_reg;
        cmd.fac_j     = j_reg;
        cmd.out_pos   = r_reg;
        cmd.out_last  = ({1'b0, r_reg} + 1'b1 == sts.count);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (req_type == smse_pkg::REQ_FEATURE) && last_feature)
                begin
                    t_next     = '0;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (t_reg == terms_c)
                begin
                    r_next     = '0;
                    state_next = mode_reg ? S_GRD : S_EFIN;
                end
                else
                begin
                    cmd.term_rd = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (mode_reg)
                begin
                    cmd.p_ld_grad = 1'b1;
                    bph_next      = 1'b1;
                end
                else
                begin
                    cmd.p_ld_mult = 1'b1;
                    j_next        = '0;
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_go     = 1'b1;
                cmd.mul_b_mult = bph_reg;
                state_next     = S_RND;
            end
            S_RND:
            begin
                cmd.rnd_go = 1'b1;
                if (bph_reg)
                begin
                    cmd.base_ld = 1'b1;
                    bph_next    = 1'b0;
                    i_next      = '0;
                    state_next  = S_GSEL;
                end
                else if (!mode_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ({1'b0, j_reg} + 1'b1 == {1'b0, order_c}) ? S_ACC : S_MUL;
                end
                else
                begin
                    j_next     = nj[smse_pkg::ORD_W-1:0];
                    state_next = (nj >= {1'b0, order_c}) ? S_GADD : S_MUL;
                end
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                t_next      = t_reg + 1'b1;
                state_next  = S_TERM;
            end
            S_GSEL:
            begin
                if (i_reg == order_c)
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_TERM;
                end
                else if (sts.tgt_ge)
                    i_next = i_reg + 1'b1;
                else
                begin
                    cmd.gacc_rd   = 1'b1;
                    cmd.p_ld_base = 1'b1;
                    j_next        = (i_reg == '0) ? 3'd1 : 3'd0;
                    state_next    = S_MUL;
                end
            end
            S_GADD:
            begin
                cmd.gacc_add = 1'b1;
                i_next       = i_reg + 1'b1;
                state_next   = S_GSEL;
            end
            S_EFIN:
            begin
                if (out_free)
                begin
                    cmd.out_ld_energy = 1'b1;
                    ov_next           = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_GRD:
            begin
                cmd.gacc_rd_out = 1'b1;
                state_next      = S_GOUT;
            end
            S_GOUT:
            begin
                if (out_free)
                begin
                    cmd.out_ld_grad = 1'b1;
                    ov_next         = 1'b1;
                    r_next          = r_reg + 1'b1;
                    state_next      = cmd.out_last ? S_IDLE : S_GRD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_mul_then_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |=> state_reg == S_RND)
        else $error("multiply not followed by rounding");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld_energy || cmd.out_ld_grad) |-> (!ov_reg || out_ready))
        else $error("output register overwritten while held");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> t_reg <= terms_c)
        else $error("term counter past term count");

    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> (j_reg < order_c || bph_reg))
        else $error("factor counter past order");

endmodule

// ----- src/sparse_monomial_sum_eval.sv -----
// Top level of the sparse monomial sum evaluator: controller plus datapath.
// Depends on smse_pkg, smse_ctrl and smse_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  cfg      | cfg_we               | cfg_index, cfg_data
//  in       | in_valid / in_ready  | req_type .. last_feature
//  out      | out_valid / out_ready| atom_energy, feature_gradient, gradient_position,
//           |                      | last_result
//
// Term loads and non-final features are accepted back to back while idle.
// A final feature starts evaluation: the energy or, in gradient mode, the gradient sums
// and then one gradient result per stored feature; the single shared multiplier and
// its rounding stage serve every product.
// Input is held off while an atom is evaluated; the last result waits in the output
// register while the next beats are taken. Reset clears control and configuration.
module sparse_monomial_sum_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [smse_pkg::TERMS_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [smse_pkg::SLOT_W-1:0]       term_slot,
    input  logic signed [smse_pkg::Q_W-1:0]   term_multiplier,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_a,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_b,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_c,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_d,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_e,
    input  logic [smse_pkg::IDX_W-1:0]        factor_index_f,
    input  logic signed [smse_pkg::Q_W-1:0]   feature_value,
    input  logic signed [smse_pkg::Q_W-1:0]   upstream_gradient,
    input  logic                              last_feature,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [smse_pkg::ACC_W-1:0] atom_energy,
    output logic signed [smse_pkg::ACC_W-1:0] feature_gradient,
    output logic [smse_pkg::IDX_W-1:0]        gradient_position,
    output logic                              last_result
);

    smse_pkg::cmd_t cmd;
    smse_pkg::sts_t sts;
    logic           in_acc;

    assign in_acc = in_valid && in_ready;

    smse_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .last_feature (last_feature),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    smse_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_acc            (in_acc),
        .req_type          (req_type),
        .term_slot         (term_slot),
        .term_multiplier   (term_multiplier),
        .factor_pack       ({factor_index_f, factor_index_e, factor_index_d,
                             factor_index_c, factor_index_b, factor_index_a}),
        .feature_value     (feature_value),
        .upstream_gradient (upstream_gradient),
        .last_feature      (last_feature),
        .cmd               (cmd),
        .sts               (sts),
        .atom_energy       (atom_energy),
        .feature_gradient  (feature_gradient),
        .gradient_position (gradient_position),
        .last_result       (last_result)
    );

endmodule
